// ===== hdl/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrt_pkg: shared types and constants of the rotated rectangle tessellator
// Command and result words, queue entry, result kinds and the sine table
// generator used at elaboration.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam logic OP_DRAW  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic        [14:0] rect_width;
    logic        [14:0] rect_height;
    logic signed [15:0] angle_deg;
    logic        [31:0] color_rgba;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic        [31:0] vert_color;
    logic        [13:0] vertex_number;
    logic        [13:0] index_a;
    logic        [13:0] index_b;
    logic        [13:0] index_c;
    logic               last;
  } res_t;

  // Reference into the quarter-wave table plus the sign of the quadrant.
  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } tab_ref_t;

  // Work word handed from the front to the back.
  typedef struct packed {
    logic               ovf;
    logic        [13:0] base;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic        [13:0] hw;
    logic        [13:0] hh;
    tab_ref_t           sin_ref;
    tab_ref_t           cos_ref;
    logic        [31:0] color;
  } work_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // sin(d degrees) in Q30 by a fixed Taylor series, clamped to 0..1.0
  function automatic longint sin_q30(input int d);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned prod;
    longint          sum;
    x    = (PI_Q30 * longint'(d)) / 180;
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = x;
    for (int k = 1; k <= 10; k++) begin
      prod = (term * x2) >> 30;
      case (k)
        1: term = prod / 6;
        2: term = prod / 20;
        3: term = prod / 42;
        4: term = prod / 72;
        5: term = prod / 110;
        6: term = prod / 156;
        7: term = prod / 210;
        8: term = prod / 272;
        9: term = prod / 342;
        default: term = prod / 420;
      endcase
      if ((k & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    return sum;
  endfunction

  // Table entry rounded half up to frac fraction bits, clamped to 1.0
  function automatic longint sin_fix(input int d, input int frac);
    longint s;
    s = sin_q30(d);
    s = (s + (longint'(1) << (29 - frac))) >> (30 - frac);
    if (s > (longint'(1) << frac)) s = longint'(1) << frac;
    return s;
  endfunction

endpackage

// ===== hdl/rotated_rect_tessellator_top.sv =====
// ----------------------------------------------------------------------------
// rotated_rect_tessellator_top: rotated rectangle to two triangles
// Turns rectangle commands into four rotated vertices and two triangles.
// ----------------------------------------------------------------------------
// A draw command yields six results on the single result port (four
// vertices bl, tl, br, tr, then triangles bl-tl-br and tr-br-tl), so with
// pop held high the block sustains one draw command per six result words;
// that limit is set by the result register, which moves one word a cycle. A
// frame-start command clears the counters in the cycle it is taken and
// yields nothing; a command that would overflow the buffers yields one
// overflow word. While the four-deep queue is not full, commands are taken
// at one a cycle while earlier ones are still being emitted; a command's
// results pass the queue, the sine and cosine, product and corner offset
// stages, the emitter and the result register. Sine and cosine come from
// a 91-entry quarter-wave table with ANGLE_FRAC_BITS fraction bits.
module rotated_rect_tessellator_top #(
  parameter int VERTEX_CAPACITY = 16384,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rrt_pkg::cmd_t cmd,
  output logic          empty,
  input  logic          pop,
  output rrt_pkg::res_t res
);

  logic           q_push;
  rrt_pkg::work_t q_wr;
  logic           q_rd;
  rrt_pkg::work_t q_head;
  logic           q_valid;

  rrt_front #(
    .VERTEX_CAPACITY(VERTEX_CAPACITY)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .cmd    (cmd),
    .q_push (q_push),
    .q_data (q_wr)
  );

  rrt_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_head),
    .valid   (q_valid)
  );

  rrt_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_head),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

endmodule

// ===== hdl/rrt_front.sv =====
// ----------------------------------------------------------------------------
// rrt_front: command intake
// Keeps the vertex and element counters, checks for buffer overflow, reduces
// the angle and resolves the sine and cosine table references.
// ----------------------------------------------------------------------------
module rrt_front #(
  parameter int VERTEX_CAPACITY = 16384
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  rrt_pkg::cmd_t  cmd,
  output logic           q_push,
  output rrt_pkg::work_t q_data
);

  localparam int ELEMENT_CAPACITY = (VERTEX_CAPACITY / 2) * 3;
  localparam int CW = $clog2(ELEMENT_CAPACITY + 7);

  logic [CW-1:0] vertex_count;
  logic [CW-1:0] element_count;
  logic          accept;
  logic          ovf;

  // (h*256 - 32768) mod 360, so the offset-binary angle needs one fold only
  logic [8:0]  mod_tab [0:255];
  logic [15:0] u;
  logic [9:0]  v;
  logic [8:0]  ang;
  logic [8:0]  ang_c;

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = 9'(((g * 256) + 352) % 360);
  end

  function automatic rrt_pkg::tab_ref_t quad_map(input logic [8:0] a);
    rrt_pkg::tab_ref_t r;
    if (a <= 9'd90) begin
      r.neg = 1'b0;
      r.idx = 7'(a);
    end else if (a <= 9'd180) begin
      r.neg = 1'b0;
      r.idx = 7'(9'd180 - a);
    end else if (a <= 9'd270) begin
      r.neg = 1'b1;
      r.idx = 7'(a - 9'd180);
    end else begin
      r.neg = 1'b1;
      r.idx = 7'(9'd360 - a);
    end
    return r;
  endfunction

  always_comb begin
    accept = push && !full;
    ovf = ((CW+1)'(vertex_count) + (CW+1)'(4) > (CW+1)'(VERTEX_CAPACITY)) ||
          ((CW+1)'(element_count) + (CW+1)'(6) > (CW+1)'(ELEMENT_CAPACITY));
    u = {~cmd.angle_deg[15], cmd.angle_deg[14:0]};
    v = {1'b0, mod_tab[u[15:8]]} + {2'b00, u[7:0]};
    ang = (v >= 10'd360) ? 9'(v - 10'd360) : 9'(v);
    ang_c = (ang < 9'd270) ? 9'(ang + 9'd90) : 9'(ang - 9'd270);

    q_push         = accept && (cmd.op == rrt_pkg::OP_DRAW);
    q_data.ovf     = ovf;
    q_data.base    = 14'(vertex_count);
    q_data.ax      = cmd.anchor_x;
    q_data.ay      = cmd.anchor_y;
    q_data.hw      = cmd.rect_width[14:1];
    q_data.hh      = cmd.rect_height[14:1];
    q_data.sin_ref = quad_map(ang);
    q_data.cos_ref = quad_map(ang_c);
    q_data.color   = cmd.color_rgba;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      element_count <= '0;
    end else if (accept) begin
      if (cmd.op == rrt_pkg::OP_FRAME) begin
        vertex_count  <= '0;
        element_count <= '0;
      end else if (!ovf) begin
        vertex_count  <= vertex_count + CW'(4);
        element_count <= element_count + CW'(6);
      end
    end
  end

endmodule

// ===== hdl/rrt_fifo.sv =====
// ----------------------------------------------------------------------------
// rrt_fifo: short work queue
// Decouples command intake from result generation.
// ----------------------------------------------------------------------------
module rrt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rrt_pkg::work_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output rrt_pkg::work_t rd_data,
  output logic           valid
);

  rrt_pkg::work_t mem [0:rrt_pkg::Q_DEPTH-1];

  logic [rrt_pkg::Q_AW-1:0] wr_ptr;
  logic [rrt_pkg::Q_AW-1:0] rd_ptr;
  logic [rrt_pkg::Q_AW:0]   count;

  assign full    = (count == (rrt_pkg::Q_AW+1)'(rrt_pkg::Q_DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/rrt_back.sv =====
// ----------------------------------------------------------------------------
// rrt_back: rotation and result generation
// Table lookup, products, corner offsets, then a six-step emitter (a single
// overflow word for an overflowing entry) feeding the result register.
// ----------------------------------------------------------------------------
module rrt_back #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  rrt_pkg::work_t q_data,
  output logic           q_rd,
  input  logic           pop,
  output logic           empty,
  output rrt_pkg::res_t  res
);

  localparam int F    = ANGLE_FRAC_BITS;
  localparam int TW   = F + 2;       // signed sine / cosine
  localparam int PW   = F + 17;      // signed product
  localparam int SUMW = F + 18;      // sum of two products
  localparam int OFFW = 18;          // corner offset after the shift
  localparam logic signed [SUMW-1:0] RND = SUMW'((longint'(1) << F) - 1);

  logic [F:0] sin_rom [0:90];

  for (genvar g = 0; g <= 90; g++) begin : g_rom
    assign sin_rom[g] = (F+1)'(rrt_pkg::sin_fix(g, F));
  end

  // stage 1: sine and cosine
  logic                 v1;
  rrt_pkg::work_t       e1;
  logic signed [TW-1:0] s1;
  logic signed [TW-1:0] c1;
  logic signed [TW-1:0] s_lut;
  logic signed [TW-1:0] c_lut;

  // stage 2: products
  logic                 v2;
  rrt_pkg::work_t       e2;
  logic signed [PW-1:0] p_wc;
  logic signed [PW-1:0] p_hs;
  logic signed [PW-1:0] p_ws;
  logic signed [PW-1:0] p_hc;
  logic signed [PW-1:0] hw_x;
  logic signed [PW-1:0] hh_x;
  logic signed [PW-1:0] s_x;
  logic signed [PW-1:0] c_x;

  // stage 3: corner offsets
  logic                   v3;
  rrt_pkg::work_t         e3;
  logic signed [OFFW-1:0] rx3 [0:3];
  logic signed [OFFW-1:0] ry3 [0:3];
  logic signed [OFFW-1:0] rx_n [0:3];
  logic signed [OFFW-1:0] ry_n [0:3];

  // emitter
  logic                   busy;
  logic [2:0]             step;
  rrt_pkg::work_t         e4;
  logic signed [OFFW-1:0] rx4 [0:3];
  logic signed [OFFW-1:0] ry4 [0:3];
  logic                   res_valid;
  rrt_pkg::res_t          res_next;

  logic take1;
  logic take2;
  logic take3;
  logic out_free;
  logic emit;
  logic fin;
  logic load;

  function automatic logic signed [OFFW-1:0] trunc_shift(input logic signed [SUMW-1:0] n);
    logic signed [SUMW-1:0] nb;
    nb = n[SUMW-1] ? (n + RND) : n;
    return OFFW'(nb >>> F);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [15:0] a,
                                               input logic signed [OFFW-1:0] d);
    logic signed [OFFW:0] t;
    t = (OFFW+1)'(a) + (OFFW+1)'(d);
    if (t > (OFFW+1)'(32767)) return 16'sh7FFF;
    if (t < -(OFFW+1)'(32768)) return 16'sh8000;
    return 16'(t);
  endfunction

  always_comb begin
    out_free = !res_valid || pop;
    emit     = busy && out_free;
    fin      = emit && (e4.ovf || (step == 3'd5));
    load     = v3 && (!busy || fin);
    take3    = v2 && (!v3 || load);
    take2    = v1 && (!v2 || take3);
    take1    = q_valid && (!v1 || take2);
    q_rd     = take1;
    empty    = !res_valid;
  end

  always_comb begin
    s_lut = TW'({1'b0, sin_rom[q_data.sin_ref.idx]});
    c_lut = TW'({1'b0, sin_rom[q_data.cos_ref.idx]});
    if (q_data.sin_ref.neg) s_lut = -s_lut;
    if (q_data.cos_ref.neg) c_lut = -c_lut;
    hw_x = PW'($signed({1'b0, e1.hw}));
    hh_x = PW'($signed({1'b0, e1.hh}));
    s_x  = PW'(s1);
    c_x  = PW'(c1);
  end

  // corner order bl, tl, br, tr: x sign from bit 1, y sign from bit 0
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rx_n[i] = trunc_shift(((i >= 2) ? SUMW'(p_wc) : -SUMW'(p_wc)) +
                            (((i & 1) == 1) ? -SUMW'(p_hs) : SUMW'(p_hs)));
      ry_n[i] = trunc_shift(((i >= 2) ? SUMW'(p_ws) : -SUMW'(p_ws)) +
                            (((i & 1) == 1) ? SUMW'(p_hc) : -SUMW'(p_hc)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (take1) v1 <= 1'b1;
      else if (take2) v1 <= 1'b0;
      if (take2) v2 <= 1'b1;
      else if (take3) v2 <= 1'b0;
      if (take3) v3 <= 1'b1;
      else if (load) v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      e1 <= q_data;
      s1 <= s_lut;
      c1 <= c_lut;
    end
    if (take2) begin
      e2   <= e1;
      p_wc <= hw_x * c_x;
      p_hs <= hh_x * s_x;
      p_ws <= hw_x * s_x;
      p_hc <= hh_x * c_x;
    end
    if (take3) begin
      e3 <= e2;
      for (int i = 0; i < 4; i++) begin
        rx3[i] <= rx_n[i];
        ry3[i] <= ry_n[i];
      end
    end
    if (load) begin
      e4 <= e3;
      for (int i = 0; i < 4; i++) begin
        rx4[i] <= rx3[i];
        ry4[i] <= ry3[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (fin) begin
      busy <= 1'b0;
    end else if (emit) begin
      step <= step + 3'd1;
    end
  end

  always_comb begin
    res_next = '0;
    if (e4.ovf) begin
      res_next.kind = rrt_pkg::KIND_OVERFLOW;
      res_next.last = 1'b1;
    end else begin
      case (step)
        3'd4: begin
          res_next.kind    = rrt_pkg::KIND_TRIANGLE;
          res_next.index_a = e4.base;
          res_next.index_b = e4.base + 14'd1;
          res_next.index_c = e4.base + 14'd2;
        end
        3'd5: begin
          res_next.kind    = rrt_pkg::KIND_TRIANGLE;
          res_next.index_a = e4.base + 14'd3;
          res_next.index_b = e4.base + 14'd2;
          res_next.index_c = e4.base + 14'd1;
          res_next.last    = 1'b1;
        end
        default: begin
          res_next.kind          = rrt_pkg::KIND_VERTEX;
          res_next.vert_x        = sat16(e4.ax, rx4[step[1:0]]);
          res_next.vert_y        = sat16(e4.ay, ry4[step[1:0]]);
          res_next.vert_color    = e4.color;
          res_next.vertex_number = e4.base + 14'(step[1:0]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= res_next;
  end

endmodule

// ===== hdl/rrt_check.sv =====
// ----------------------------------------------------------------------------
// rrt_check: result port checks
// Watches the result side of the tessellator over time.
// ----------------------------------------------------------------------------
module rrt_check (
  input logic          clk,
  input logic          rst,
  input logic          empty,
  input logic          pop,
  input rrt_pkg::res_t res
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(res))
    else $error("stalled result word changed");

  a_tri_first: assert property (@(posedge clk) disable iff (rst)
    !empty && res.kind == rrt_pkg::KIND_TRIANGLE && !res.last |->
      res.index_b == 14'(res.index_a + 14'd1) &&
      res.index_c == 14'(res.index_a + 14'd2))
    else $error("first triangle indices out of order");

  a_tri_second: assert property (@(posedge clk) disable iff (rst)
    !empty && res.kind == rrt_pkg::KIND_TRIANGLE && res.last |->
      res.index_b == 14'(res.index_a - 14'd1) &&
      res.index_c == 14'(res.index_a - 14'd2))
    else $error("second triangle indices out of order");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    !empty && res.kind == rrt_pkg::KIND_OVERFLOW |->
      res.last && res.vertex_number == '0 && res.index_a == '0)
    else $error("overflow word malformed");

endmodule

bind rotated_rect_tessellator_top rrt_check u_check (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .res   (res)
);

// ===== tb/sv/rotated_rect_tessellator_top_tb.sv =====
// ----------------------------------------------------------------------------
// rotated_rect_tessellator_top_tb: self-checking bench for the tessellator
// Sends rectangle and frame-start commands through the push/full port and
// predicts every vertex, triangle and overflow word from its own model of
// the rotation and the two buffer counters. Each popped word is compared
// field by field with the oldest prediction. The bench covers directed
// corner cases and random commands under three idling patterns.
// ----------------------------------------------------------------------------
module rotated_rect_tessellator_top_tb;

  localparam int VTX_CAP     = 16384;
  localparam int ELEM_CAP    = (VTX_CAP / 2) * 3;
  localparam int FRAC        = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;
  localparam longint unsigned PI_SCALED = 64'd3373259426;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          full;
  rrt_pkg::cmd_t cmd = '0;
  logic          empty;
  logic          pop = 1'b0;
  rrt_pkg::res_t res;

  int            vtx_count = 0;
  int            elem_count = 0;
  rrt_pkg::res_t expected_words[$];
  int            fail_count = 0;
  int            push_idle_pct = 10;
  int            pop_idle_pct = 86;
  int            stall_cycles = 0;

  rotated_rect_tessellator_top #(
    .VERTEX_CAPACITY(VTX_CAP),
    .ANGLE_FRAC_BITS(FRAC)
  ) uut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .cmd  (cmd),
    .empty(empty),
    .pop  (pop),
    .res  (res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // sin(d) for d in 0..90, Taylor series in Q30 then rounded to FRAC bits
  function automatic longint quarter_sine(input int d);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    if (d > 90) d = 90;
    x    = (PI_SCALED * d) / 180;
    x2   = (x * x) >> 30;
    acc  = longint'(x);
    term = x;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    acc = (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    if (acc > (longint'(1) << FRAC)) acc = longint'(1) << FRAC;
    return acc;
  endfunction

  function automatic longint sine_fixed(input int a);
    if (a <= 90) return quarter_sine(a);
    if (a <= 180) return quarter_sine(180 - a);
    if (a <= 270) return -quarter_sine(a - 180);
    return -quarter_sine(360 - a);
  endfunction

  function automatic longint shift_toward_zero(input longint n);
    if (n < 0) return -((-n) >>> FRAC);
    return n >>> FRAC;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Expected words for one accepted command; updates the buffer counters
  function automatic void tessellate(input rrt_pkg::cmd_t rc);
    rrt_pkg::res_t w;
    int            ang;
    int            hw;
    int            hh;
    longint        sn;
    longint        cs;
    longint        dx;
    longint        dy;
    logic [13:0]   num [4];
    if (rc.op == rrt_pkg::OP_FRAME) begin
      vtx_count  = 0;
      elem_count = 0;
      return;
    end
    if (vtx_count + 4 > VTX_CAP || elem_count + 6 > ELEM_CAP) begin
      w      = '0;
      w.kind = rrt_pkg::KIND_OVERFLOW;
      w.last = 1'b1;
      expected_words.push_back(w);
      return;
    end
    hw  = int'(rc.rect_width) / 2;
    hh  = int'(rc.rect_height) / 2;
    ang = int'(rc.angle_deg) % 360;
    if (ang < 0) ang += 360;
    sn = sine_fixed(ang);
    cs = sine_fixed((ang + 90) % 360);
    // corners in order bl, tl, br, tr
    for (int i = 0; i < 4; i++) begin
      dx     = (i < 2) ? -hw : hw;
      dy     = (i % 2 == 1) ? hh : -hh;
      num[i] = 14'(vtx_count + i);
      w      = '0;
      w.kind = rrt_pkg::KIND_VERTEX;
      w.vert_x = clamp16(longint'(rc.anchor_x) + shift_toward_zero(dx * cs - dy * sn));
      w.vert_y = clamp16(longint'(rc.anchor_y) + shift_toward_zero(dx * sn + dy * cs));
      w.vert_color    = rc.color_rgba;
      w.vertex_number = num[i];
      expected_words.push_back(w);
    end
    w         = '0;
    w.kind    = rrt_pkg::KIND_TRIANGLE;
    w.index_a = num[0];
    w.index_b = num[1];
    w.index_c = num[2];
    expected_words.push_back(w);
    w.index_a = num[3];
    w.index_b = num[2];
    w.index_c = num[1];
    w.last    = 1'b1;
    expected_words.push_back(w);
    vtx_count  += 4;
    elem_count += 6;
  endfunction

  function automatic rrt_pkg::cmd_t make_draw(input int ax, input int ay, input int wd,
                                              input int ht, input int ang,
                                              input logic [31:0] col);
    rrt_pkg::cmd_t rc;
    rc.op          = rrt_pkg::OP_DRAW;
    rc.anchor_x    = 16'(ax);
    rc.anchor_y    = 16'(ay);
    rc.rect_width  = 15'(wd);
    rc.rect_height = 15'(ht);
    rc.angle_deg   = 16'(ang);
    rc.color_rgba  = col;
    return rc;
  endfunction

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_size();
    case ($urandom_range(7))
      0: return 15'd0;
      1: return 15'h7fff;
      2, 3: return 15'($urandom);
      default: return 15'($urandom_range(200));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(3))
      0: return 16'(int'($urandom_range(16)) * 90 - 720);
      1: return 16'($urandom_range(359));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rrt_pkg::cmd_t random_cmd(input bit allow_frame);
    rrt_pkg::cmd_t rc;
    rc.op          = (allow_frame && $urandom_range(99) < 8) ? rrt_pkg::OP_FRAME
                                                             : rrt_pkg::OP_DRAW;
    rc.anchor_x    = pick_coord();
    rc.anchor_y    = pick_coord();
    rc.rect_width  = pick_size();
    rc.rect_height = pick_size();
    rc.angle_deg   = pick_angle();
    rc.color_rgba  = $urandom;
    return rc;
  endfunction

  // Leaves push high on return so back-to-back words need no gap
  task automatic send_cmd(input rrt_pkg::cmd_t rc);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd  <= rc;
    do @(posedge clk); while (full);
    tessellate(rc);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic test_directed();
    rrt_pkg::cmd_t rc;
    rc    = random_cmd(1'b0);
    rc.op = rrt_pkg::OP_FRAME;
    send_cmd(rc);
    send_cmd(make_draw(0, 0, 0, 0, 0, 32'h0000_0000));
    send_cmd(make_draw(100, -50, 41, 17, 0, 32'hffff_ffff));
    send_cmd(make_draw(-20, 30, 60, 20, 90, 32'h1122_3344));
    send_cmd(make_draw(5, 5, 61, 21, 180, 32'h5566_7788));
    send_cmd(make_draw(-7, 9, 100, 40, 270, 32'h99aa_bbcc));
    send_cmd(make_draw(0, 0, 200, 100, 359, 32'hddee_ff00));
    send_cmd(make_draw(10, -10, 200, 100, -1, 32'h0f0f_0f0f));
    send_cmd(make_draw(1, 2, 33, 55, -360, 32'hf0f0_f0f0));
    send_cmd(make_draw(3, 4, 55, 33, 360, 32'h0000_00ff));
    send_cmd(make_draw(-100, 100, 77, 88, 32767, 32'hff00_0000));
    send_cmd(make_draw(100, -100, 88, 77, -32768, 32'h00ff_00ff));
    send_cmd(make_draw(0, 0, 32767, 32767, 45, 32'h8000_0001));
    // drive corners past the positive and the negative rail
    send_cmd(make_draw(32767, 32767, 32767, 32767, 0, 32'h7fff_fffe));
    send_cmd(make_draw(-32768, -32768, 32767, 32767, 30, 32'h1234_5678));
    send_cmd(make_draw(-1, 1, 1, 1, 123, 32'hcafe_f00d));
    rc    = random_cmd(1'b0);
    rc.op = rrt_pkg::OP_FRAME;
    send_cmd(rc);
    send_cmd(make_draw(12, 34, 40, 30, 30, 32'h1234_5678));
    send_cmd(make_draw(0, 0, 32766, 3, 135, 32'h0bad_beef));
    send_cmd(make_draw(32767, -32768, 32767, 7, 225, 32'hdead_0001));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_cmd(random_cmd(1'b1));
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  always @(posedge clk) begin : check_results
    rrt_pkg::res_t want;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with none expected, kind", 32'(res.kind), 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (res.kind !== want.kind)
          report_mismatch("kind", 32'(res.kind), 32'(want.kind));
        if (res.vert_x !== want.vert_x)
          report_mismatch("vert_x", 32'(res.vert_x), 32'(want.vert_x));
        if (res.vert_y !== want.vert_y)
          report_mismatch("vert_y", 32'(res.vert_y), 32'(want.vert_y));
        if (res.vert_color !== want.vert_color)
          report_mismatch("vert_color", res.vert_color, want.vert_color);
        if (res.vertex_number !== want.vertex_number)
          report_mismatch("vertex_number", 32'(res.vertex_number), 32'(want.vertex_number));
        if (res.index_a !== want.index_a)
          report_mismatch("index_a", 32'(res.index_a), 32'(want.index_a));
        if (res.index_b !== want.index_b)
          report_mismatch("index_b", 32'(res.index_b), 32'(want.index_b));
        if (res.index_c !== want.index_c)
          report_mismatch("index_c", 32'(res.index_c), 32'(want.index_c));
        if (res.last !== want.last)
          report_mismatch("last", 32'(res.last), 32'(want.last));
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(30);
    push_idle_pct = 86;
    pop_idle_pct  = 10;
    test_random(30);
    push_idle_pct = 0;
    pop_idle_pct  = 0;
    test_random(20);
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    // hold a little longer to catch stray words
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("words still expected", 32'(expected_words.size()), 32'd0);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
